>>> rtl/ffc_pkg.sv
// Package for the flow field curl stencil: payload structs, line buffer entry,
// queue descriptor flags, register indexes and field widths.
// Depends on nothing; every other file of the block imports it.
package ffc_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int CURL_BITS       = SAMPLE_BITS + 2;
    localparam int ROW_BITS        = 12;
    localparam int COL_BITS        = 10;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 12;
    localparam int CFG_DATA_BITS   = 12;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [WIDTH_REG_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd128;
    localparam logic [HEIGHT_REG_BITS-1:0] FRAME_HEIGHT_RESET = 12'd128;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] flow_x;
        logic signed [SAMPLE_BITS-1:0] flow_y;
    } flow_in_t;

    typedef struct packed {
        logic signed [CURL_BITS-1:0] curl_value;
        logic [ROW_BITS-1:0]         out_row;
        logic [COL_BITS-1:0]         out_col;
        logic                        end_of_frame;
        logic                        last_of_run;
    } curl_out_t;

    // Classification of one accepted request, decided by the front end.
    typedef struct packed {
        logic emit_prev;   // a result for the pixel one row up is due
        logic emit_own;    // last row: a zero result for this pixel is due
        logic border;      // the pixel one row up lies on the frame border
        logic col_last;    // this pixel is in the last column
    } desc_flags_t;

    // One line buffer entry: vx two rows back, and (vx, vy) one row back.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] older_x;
        logic signed [SAMPLE_BITS-1:0] prev_x;
        logic signed [SAMPLE_BITS-1:0] prev_y;
    } line_entry_t;

    function automatic logic signed [CURL_BITS-1:0] widen(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        return {{(CURL_BITS - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

endpackage

>>> rtl/flow_field_curl_stencil_core.sv
// Top level of the streaming flow field curl stencil.
// Instantiates ffc_front, ffc_queue and ffc_back; uses ffc_pkg.
//
//   Channel  Direction  Handshake                Payload
//   flow     in         flow_valid / flow_stall  flow_in_t  (flow_x, flow_y)
//   curl     out        curl_valid / curl_stall  curl_out_t (value, row, col, flags)
//   cfg      in         cfg_write                cfg_index, cfg_data
//
// One flow request is taken per cycle while flow_stall is low. Every request
// of a frame's last row below row 0 produces two results, so on that row the
// back end takes no new request while the second result waits in its slot;
// elsewhere a request yields at most one result, and in a single-row frame
// each request yields exactly one. A request passes through the queue and
// then the output register before its first result appears. Reset clears the
// position counters, the queue and the output; the line buffer holds no reset
// state and is read for every request taken, and border results are zero. A
// stall on the result side backs up the four-entry queue before flow_stall
// rises; the line buffer read happens as the back end takes a request.
// The front end keeps the raster position and decides for each request
// which results it causes and whether the pixel above lies on the border.
// The back end reads one line buffer entry per request, two columns ahead
// of the current column, so the entries for the left, center and right
// columns sit in a short register chain when the stencil is evaluated.
// Each entry holds vx from two rows back together with vx and vy from the
// row above; the same request writes the entry of its own column.
module flow_field_curl_stencil_core
    import ffc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      flow_valid,
    output logic                      flow_stall,
    input  flow_in_t                  flow,
    output logic                      curl_valid,
    input  logic                      curl_stall,
    output curl_out_t                 curl
);

    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int DESC_BITS   = $bits(desc_flags_t) + ROW_BITS + 2 * CW + $bits(flow_in_t);

    logic                push;
    logic                q_full;
    logic                q_valid;
    logic                pop;

    desc_flags_t         front_flags;
    logic [ROW_BITS-1:0] front_row;
    logic [CW-1:0]       front_col;
    logic [CW-1:0]       front_raddr;

    logic [DESC_BITS-1:0] push_data;
    logic [DESC_BITS-1:0] pop_data;

    desc_flags_t         back_flags;
    logic [ROW_BITS-1:0] back_row;
    logic [CW-1:0]       back_col;
    logic [CW-1:0]       back_raddr;
    flow_in_t            back_sample;

    ffc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .flow_valid (flow_valid),
        .flow_stall (flow_stall),
        .q_full     (q_full),
        .push       (push),
        .desc_flags (front_flags),
        .desc_row   (front_row),
        .desc_col   (front_col),
        .desc_raddr (front_raddr)
    );

    // The queue carries the classification together with the sample itself.
    assign push_data = {front_flags, front_row, front_col, front_raddr, flow};

    ffc_queue #(
        .WIDTH (DESC_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_data  (pop_data)
    );

    assign {back_flags, back_row, back_col, back_raddr, back_sample} = pop_data;

    ffc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .pop         (pop),
        .desc_flags  (back_flags),
        .desc_row    (back_row),
        .desc_col    (back_col),
        .desc_raddr  (back_raddr),
        .desc_sample (back_sample),
        .curl_valid  (curl_valid),
        .curl_stall  (curl_stall),
        .curl        (curl)
    );

endmodule

>>> rtl/ffc_front.sv
// Front end of the curl stencil: configuration registers, raster position
// counters and classification of each accepted request. Uses ffc_pkg.
module ffc_front
    import ffc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = $clog2(MAX_WIDTH)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       flow_valid,
    output logic                       flow_stall,
    input  logic                       q_full,
    output logic                       push,
    output desc_flags_t                desc_flags,
    output logic [ROW_BITS-1:0]        desc_row,
    output logic [CW-1:0]              desc_col,
    output logic [CW-1:0]              desc_raddr
);

    localparam int WW   = CW + 1;
    localparam int CMPW = (WW > WIDTH_REG_BITS) ? WW : WIDTH_REG_BITS;

    logic [WIDTH_REG_BITS-1:0]  frame_width_reg;
    logic [HEIGHT_REG_BITS-1:0] frame_height_reg;
    logic [ROW_BITS-1:0]        row_reg, row_next;
    logic [CW-1:0]              col_reg, col_next;

    logic [WW-1:0]              w_eff;
    logic [CW-1:0]              last_col;
    logic [HEIGHT_REG_BITS-1:0] h_eff;
    logic [ROW_BITS-1:0]        last_row;
    logic [WW-1:0]              col_plus1;
    logic [WW-1:0]              col_plus2;

    assign flow_stall = q_full;
    assign push       = flow_valid && !q_full;

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (CMPW'(frame_width_reg) > CMPW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(frame_width_reg);
        end
        h_eff     = (frame_height_reg == '0) ? HEIGHT_REG_BITS'(1) : frame_height_reg;
        last_col  = CW'(w_eff - WW'(1));
        last_row  = ROW_BITS'(h_eff - HEIGHT_REG_BITS'(1));
        col_plus1 = WW'(col_reg) + WW'(1);
        col_plus2 = WW'(col_reg) + WW'(2);

        // The line buffer is read two columns ahead, wrapping into the next row.
        desc_raddr = (col_plus2 >= w_eff) ? CW'(col_plus2 - w_eff) : CW'(col_plus2);
        desc_row   = row_reg;
        desc_col   = col_reg;

        desc_flags.emit_prev = (row_reg != '0);
        desc_flags.emit_own  = (row_reg == last_row);
        desc_flags.border    = (row_reg == ROW_BITS'(1)) || (col_reg == '0)
                               || (col_reg == last_col);
        desc_flags.col_last  = (col_reg == last_col);

        if (col_plus1 == w_eff)
        begin
            col_next = '0;
            row_next = (row_reg == last_row) ? '0 : row_reg + ROW_BITS'(1);
        end
        else
        begin
            col_next = CW'(col_plus1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            row_reg          <= '0;
            col_reg          <= '0;
        end
        else if (cfg_write && cfg_index == REG_FRAME_WIDTH)
        begin
            frame_width_reg <= cfg_data[WIDTH_REG_BITS-1:0];
            row_reg         <= '0;
            col_reg         <= '0;
        end
        else if (cfg_write && cfg_index == REG_FRAME_HEIGHT)
        begin
            frame_height_reg <= cfg_data[HEIGHT_REG_BITS-1:0];
            row_reg          <= '0;
            col_reg          <= '0;
        end
        else if (push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

>>> rtl/ffc_queue.sv
// Small register FIFO that decouples the stencil front end from the back end.
// Uses ffc_pkg only for house consistency of imports.
module ffc_queue
    import ffc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == NW'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/ffc_back.sv
// Back end of the curl stencil: line buffer memory, neighbor registers,
// the stencil arithmetic and the two-slot result output. Uses ffc_pkg.
module ffc_back
    import ffc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = $clog2(MAX_WIDTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                pop,
    input  desc_flags_t         desc_flags,
    input  logic [ROW_BITS-1:0] desc_row,
    input  logic [CW-1:0]       desc_col,
    input  logic [CW-1:0]       desc_raddr,
    input  flow_in_t            desc_sample,
    output logic                curl_valid,
    input  logic                curl_stall,
    output curl_out_t           curl
);

    line_entry_t line_mem [MAX_WIDTH];

    // Neighbors of the current column: vy one column left, the entry of this
    // column and the entry one column right, all from the rows above.
    logic signed [SAMPLE_BITS-1:0] left_vy_reg;
    line_entry_t                   cur_reg;
    line_entry_t                   next_reg;

    curl_out_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    curl_out_t pend_reg, pend_next;
    logic      pend_valid_reg, pend_valid_next;

    logic                        out_free;
    logic signed [CURL_BITS-1:0] stencil;
    curl_out_t                   res_prev, res_own;
    line_entry_t                 wr_entry;

    assign out_free   = !out_valid_reg || !curl_stall;
    assign pop        = q_valid && !pend_valid_reg && out_free;
    assign curl_valid = out_valid_reg;
    assign curl       = out_reg;

    always_comb
    begin
        stencil = (widen(left_vy_reg) - widen(next_reg.prev_y))
                  - (widen(cur_reg.older_x) - widen(desc_sample.flow_x));

        res_prev.curl_value   = desc_flags.border ? '0 : stencil;
        res_prev.out_row      = desc_row - ROW_BITS'(1);
        res_prev.out_col      = COL_BITS'(desc_col);
        res_prev.end_of_frame = 1'b0;
        res_prev.last_of_run  = !desc_flags.emit_own;

        res_own.curl_value    = '0;
        res_own.out_row       = desc_row;
        res_own.out_col       = COL_BITS'(desc_col);
        res_own.end_of_frame  = desc_flags.col_last;
        res_own.last_of_run   = 1'b1;

        wr_entry.older_x = cur_reg.prev_x;
        wr_entry.prev_x  = desc_sample.flow_x;
        wr_entry.prev_y  = desc_sample.flow_y;

        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (pop && desc_flags.emit_prev)
            begin
                out_next        = res_prev;
                out_valid_next  = 1'b1;
                pend_next       = res_own;
                pend_valid_next = desc_flags.emit_own;
            end
            else if (pop && desc_flags.emit_own)
            begin
                out_next       = res_own;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
        if (pop)
        begin
            line_mem[desc_col] <= wr_entry;
            next_reg           <= line_mem[desc_raddr];
            cur_reg            <= next_reg;
            left_vy_reg        <= cur_reg.prev_y;
        end
    end

    a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result waits without a result on the output");

    a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !pop)
        else $error("request taken while a second result is still pending");

    a_run_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last_of_run) |-> pend_valid_reg)
        else $error("result marked as not last of run without a follower");

endmodule
